// ----- sv/svl_pkg.sv -----
// Shared types and constants for the sorted value list.
package svl_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned PositionW = 4;

  localparam logic [ValueW-1:0] ValueNone = '1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_TEST  = 2'd2,
    ST_PLACE = 2'd3
  } state_e;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

// ----- sv/svl_mem.sv -----
// Entry storage: one write port and one read port with registered read data.
module svl_mem import svl_pkg::*; #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic signed [ValueW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic signed [ValueW-1:0] rdata_o
);

  logic signed [ValueW-1:0] mem_q [Depth];
  logic signed [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/svl_cmp.sv -----
// Shared signed comparator used by every scan step.
module svl_cmp import svl_pkg::*; (
  input  logic signed [ValueW-1:0] a_i,
  input  logic signed [ValueW-1:0] b_i,
  output cmp_t                     res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// ----- sv/sorted_value_list_core.sv -----
// Sorted value list: sequencer, entry count and output register around a shared comparator.
//
// Usage: an input beat (action_i, item_value_i, position_i) is taken when in_valid_i is high
// and in_stall_o is low. Each beat yields exactly one output beat (ok_o, read_value_o,
// entry_count_o) on out_valid_o, taken when out_stall_i is low.
// Entries live in a single-port-read memory and are visited one at a time (read in ST_FETCH, then
// compare and optionally write back through the one comparator in ST_TEST), so the memory read
// latency and the scan loop set the timing:
//   insert: settled without the scan when full or empty, else one FETCH/TEST pass per entry moved
//           plus the one that stops the walk, or a final ST_PLACE when the value lands in slot 0;
//   remove: one pass per entry (the scan also moves the tail down); search: passes up to the hit,
//           or over every entry when absent; remove and search skip the scan on an empty list;
//   read: one FETCH/TEST pass when valid, settled without the scan when past the count.
// The block takes one beat at a time and is stalled until that beat's result is registered.
// A result waiting under out_stall_i holds its payload, and a new beat is taken in the same
// cycle the old result leaves. Reset empties the list (count zero) and needs no clearing pass;
// the entry memory itself is not reset.
module sorted_value_list_core import svl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [ValueW-1:0] item_value_i,
  input  logic [PositionW-1:0]     position_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     ok_o,
  output logic signed [ValueW-1:0] read_value_o,
  output logic [CountOutW-1:0]     entry_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > PositionW) ? CW : PositionW;
  localparam int EW = CW + CountOutW;
  localparam logic [CW-1:0] CntFull = CW'(CAPACITY);

  state_e state_q, state_d;
  action_e op_q, op_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic found_q, found_d;

  logic out_valid_q, out_valid_d;
  logic ok_q;
  logic signed [ValueW-1:0] rv_q;
  logic [CountOutW-1:0] ec_q;

  logic accept;
  logic fast_done;
  logic test_done;
  logic last_idx;
  logic place_next;
  logic pos_valid;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [EW-1:0] cnt_wide;

  logic finish;
  logic fin_ok;
  logic signed [ValueW-1:0] fin_rv;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [ValueW-1:0] mem_wdata;
  logic mem_re;
  logic [AW-1:0] mem_raddr;
  logic signed [ValueW-1:0] mem_rdata;
  cmp_t cmp;

  svl_mem #(
    .Depth(CAPACITY),
    .AddrW(AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  svl_cmp u_cmp (
    .a_i  (mem_rdata),
    .b_i  (val_q),
    .res_o(cmp)
  );

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;

  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(cnt_q);
  assign pos_valid = (pos_ext < cnt_ext);

  assign last_idx = ((idx_q + CW'(1)) == cnt_q);
  assign place_next = (idx_q == CW'(1));

  // Beats that are settled without touching the scan loop.
  always_comb begin
    fast_done = 1'b0;
    case (action_e'(action_i))
      ACT_INSERT: fast_done = (cnt_q == CntFull) || (cnt_q == '0);
      ACT_REMOVE, ACT_SEARCH: fast_done = (cnt_q == '0);
      ACT_READ: fast_done = !pos_valid;
      default: fast_done = 1'b1;
    endcase
  end

  always_comb begin
    test_done = 1'b1;
    case (op_q)
      ACT_INSERT: test_done = cmp.lt;
      ACT_REMOVE: test_done = last_idx;
      ACT_SEARCH: test_done = cmp.eq || last_idx;
      ACT_READ: test_done = 1'b1;
      default: test_done = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !fast_done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_TEST;
      ST_TEST: begin
        if (test_done) begin
          state_d = ST_IDLE;
        end else if (op_q == ACT_INSERT && place_next) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_PLACE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and result.
  always_comb begin
    op_d = op_q;
    val_d = val_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    found_d = found_q;
    mem_we = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = val_q;
    mem_re = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    finish = 1'b0;
    fin_ok = 1'b0;
    fin_rv = ValueNone;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = action_e'(action_i);
          val_d = item_value_i;
          found_d = 1'b0;
          idx_d = '0;
          case (action_e'(action_i))
            ACT_INSERT: begin
              idx_d = cnt_q;
              if (cnt_q == '0) begin
                mem_we = 1'b1;
                mem_waddr = '0;
                mem_wdata = item_value_i;
                cnt_d = CW'(1);
                finish = 1'b1;
                fin_ok = 1'b1;
              end else if (cnt_q == CntFull) begin
                finish = 1'b1;
              end
            end
            ACT_REMOVE, ACT_SEARCH: begin
              finish = (cnt_q == '0);
            end
            ACT_READ: begin
              idx_d = CW'(pos_ext);
              finish = !pos_valid;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_FETCH: begin
        mem_re = 1'b1;
        // Insert walks down from the top, so it looks one slot below the gap.
        if (op_q == ACT_INSERT) begin
          mem_raddr = AW'(idx_q - CW'(1));
        end
      end
      ST_TEST: begin
        case (op_q)
          ACT_INSERT: begin
            mem_we = 1'b1;
            if (cmp.lt) begin
              mem_wdata = val_q;
              cnt_d = cnt_q + CW'(1);
              finish = 1'b1;
              fin_ok = 1'b1;
            end else begin
              mem_wdata = mem_rdata;
              idx_d = idx_q - CW'(1);
            end
          end
          ACT_REMOVE: begin
            // Once the match is behind us, every later entry moves down one slot.
            if (found_q) begin
              mem_we = 1'b1;
              mem_waddr = AW'(idx_q - CW'(1));
              mem_wdata = mem_rdata;
            end else if (cmp.eq) begin
              found_d = 1'b1;
            end
            idx_d = idx_q + CW'(1);
            if (last_idx) begin
              finish = 1'b1;
              fin_ok = found_q || cmp.eq;
              if (found_q || cmp.eq) begin
                cnt_d = cnt_q - CW'(1);
              end
            end
          end
          ACT_SEARCH: begin
            idx_d = idx_q + CW'(1);
            if (cmp.eq || last_idx) begin
              finish = 1'b1;
              fin_ok = cmp.eq;
            end
          end
          ACT_READ: begin
            finish = 1'b1;
            fin_ok = 1'b1;
            fin_rv = mem_rdata;
          end
          default: finish = 1'b1;
        endcase
      end
      ST_PLACE: begin
        mem_we = 1'b1;
        mem_waddr = '0;
        mem_wdata = val_q;
        cnt_d = cnt_q + CW'(1);
        finish = 1'b1;
        fin_ok = 1'b1;
      end
      default: finish = 1'b0;
    endcase
  end

  assign cnt_wide = EW'(cnt_d);
  assign out_valid_d = finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    val_q <= val_d;
    idx_q <= idx_d;
    found_q <= found_d;
    if (finish) begin
      ok_q <= fin_ok;
      rv_q <= fin_rv;
      ec_q <= cnt_wide[CountOutW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o = ok_q;
  assign read_value_o = rv_q;
  assign entry_count_o = ec_q;

endmodule

// ----- dv/sorted_value_list_core_tb.sv -----
// Self-checking testbench for the sorted value list core: directed and random beats.
module sorted_value_list_core_tb import svl_pkg::*;;

  localparam int ListDepth = 16;
  localparam int RandomBeats = 1850;
  localparam int WindDownBeats = 150;
  localparam int DrainCycles = 60;
  localparam int WatchdogLimit = 3000;
  localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MaxValue = 32'sh7fff_ffff;

  typedef struct {
    action_e                     action;
    logic signed [ValueW-1:0]    value;
    logic [PositionW-1:0]        position;
  } request_t;

  typedef struct {
    logic                        ok;
    logic signed [ValueW-1:0]    read_value;
    logic [CountOutW-1:0]        entry_count;
  } outcome_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  action_e                     in_action = ACT_INSERT;
  logic signed [ValueW-1:0]    in_value = '0;
  logic [PositionW-1:0]        in_position = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        ok;
  logic signed [ValueW-1:0]    read_value;
  logic [CountOutW-1:0]        entry_count;

  // Shadow copy of the list, kept in ascending order in slots 0 to held_count-1.
  logic signed [ValueW-1:0]    held [ListDepth];
  int                          held_count = 0;

  request_t                    request_queue[$];
  outcome_t                    pending_outcomes[$];
  logic signed [ValueW-1:0]    value_pool[$];
  int                          beats_sent = 0;
  int                          beats_taken = 0;
  int                          in_gap = 0;
  int                          in_calm = 0;
  int                          stall_left = 0;
  int                          stall_calm = 0;
  int                          quiet_cycles = 0;
  logic                        mismatch_seen = 1'b0;

  sorted_value_list_core #(
    .CAPACITY(ListDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (in_action),
    .item_value_i (in_value),
    .position_i   (in_position),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .ok_o         (ok),
    .read_value_o (read_value),
    .entry_count_o(entry_count)
  );

  always #5 clk_i = ~clk_i;

  // Applies one action to the shadow list and returns the result the block should give.
  function automatic outcome_t list_apply(action_e act, logic signed [ValueW-1:0] value,
                                          logic [PositionW-1:0] position);
    outcome_t res;
    int slot;
    int k;
    res.ok = 1'b0;
    res.read_value = ValueNone;
    slot = 0;
    case (act)
      ACT_INSERT: begin
        if (held_count < ListDepth) begin
          while (slot < held_count && held[slot] < value) slot++;
          for (k = held_count; k > slot; k--) held[k] = held[k-1];
          held[slot] = value;
          held_count++;
          res.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        while (slot < held_count && held[slot] != value) slot++;
        if (slot < held_count) begin
          for (k = slot; k + 1 < held_count; k++) held[k] = held[k+1];
          held_count--;
          res.ok = 1'b1;
        end
      end
      ACT_SEARCH: begin
        for (k = 0; k < held_count; k++) if (held[k] == value) res.ok = 1'b1;
      end
      default: begin
        if (int'(position) < held_count) begin
          res.ok = 1'b1;
          res.read_value = held[position];
        end
      end
    endcase
    res.entry_count = CountOutW'(held_count);
    return res;
  endfunction

  // Length of the next idle burst; a calm stretch suppresses bursts for a while.
  function automatic int idle_burst(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    case ($urandom_range(0, 39))
      0: begin
        calm = $urandom_range(30, 120);
        return 0;
      end
      1, 2, 3, 4, 5: return $urandom_range(1, 17);
      default: return 0;
    endcase
  endfunction

  task automatic queue_request(action_e act, logic signed [ValueW-1:0] value,
                               logic [PositionW-1:0] position);
    request_t req;
    req.action = act;
    req.value = value;
    req.position = position;
    request_queue.push_back(req);
    if (act == ACT_INSERT) begin
      value_pool.push_back(value);
      if (value_pool.size() > 24) void'(value_pool.pop_front());
    end
  endtask

  function automatic logic signed [ValueW-1:0] pick_value(int pool_pct);
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 15)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: return MinValue;
          1: return MaxValue;
          2: return '0;
          default: return -1;
        endcase
      end
      default: begin
        if (value_pool.size() > 0 && $urandom_range(0, 99) < pool_pct)
          return value_pool[$urandom_range(0, value_pool.size() - 1)];
        return $signed($urandom);
      end
    endcase
  endfunction

  // Fill, mixed and drain phases alternate so the list reaches full and empty repeatedly.
  task automatic queue_random(int n);
    int roll;
    int phase;
    int ins_pct;
    int rem_pct;
    for (int i = 0; i < n; i++) begin
      phase = (i / 60) % 3;
      ins_pct = (phase == 0) ? 60 : (phase == 1) ? 25 : 10;
      rem_pct = (phase == 0) ? 10 : (phase == 1) ? 25 : 60;
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        queue_request(ACT_INSERT, pick_value(30), PositionW'($urandom));
      else if (roll < ins_pct + rem_pct)
        queue_request(ACT_REMOVE, pick_value(90), PositionW'($urandom));
      else if (roll < ins_pct + rem_pct + (100 - ins_pct - rem_pct) / 2)
        queue_request(ACT_SEARCH, pick_value(50), PositionW'($urandom));
      else
        queue_request(ACT_READ, $signed($urandom), PositionW'($urandom));
    end
  endtask

  always @(negedge clk_i) begin : driver
    request_t req;
    logic wind_down;
    if (rst_ni) begin
      wind_down = request_queue.size() < WindDownBeats;
      if (beats_taken == beats_sent) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (request_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          req = request_queue.pop_front();
          in_action <= req.action;
          in_value <= req.value;
          in_position <= req.position;
          in_valid <= 1'b1;
          beats_sent++;
          if (!wind_down) in_gap = idle_burst(in_calm);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!wind_down) stall_left = idle_burst(stall_calm);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    outcome_t want;
    logic in_fire;
    logic out_fire;
    if (rst_ni) begin
      in_fire = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (in_fire) begin
        pending_outcomes.push_back(list_apply(in_action, in_value, in_position));
        beats_taken++;
      end
      if (out_fire) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat with nothing expected (ok %0d, value %0d, count %0d)",
                   $time, ok, read_value, entry_count);
          mismatch_seen = 1'b1;
        end else begin
          want = pending_outcomes.pop_front();
          if (ok !== want.ok) begin
            $display("%0t: ok expected %0d, actual %0d", $time, want.ok, ok);
            mismatch_seen = 1'b1;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d, actual %0d",
                     $time, want.read_value, read_value);
            mismatch_seen = 1'b1;
          end
          if (entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, actual %0d",
                     $time, want.entry_count, entry_count);
            mismatch_seen = 1'b1;
          end
        end
      end
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
          $display("sorted_value_list_core regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    // Empty list: search, remove and read all miss.
    queue_request(ACT_SEARCH, '0, '0);
    queue_request(ACT_REMOVE, 5, '0);
    queue_request(ACT_READ, '0, '0);
    // Extremes, a duplicate, and signed ordering of the all-ones pattern.
    queue_request(ACT_INSERT, '0, '0);
    queue_request(ACT_INSERT, MaxValue, '0);
    queue_request(ACT_INSERT, MinValue, '0);
    queue_request(ACT_INSERT, -1, '0);
    queue_request(ACT_INSERT, '0, '0);
    queue_request(ACT_INSERT, 1, '0);
    queue_request(ACT_READ, '0, 4'd0);
    queue_request(ACT_READ, '0, 4'd5);
    queue_request(ACT_READ, '0, 4'd6);
    queue_request(ACT_READ, '0, 4'd15);
    queue_request(ACT_SEARCH, -1, '0);
    queue_request(ACT_SEARCH, 2, '0);
    queue_request(ACT_REMOVE, '0, '0);
    queue_request(ACT_SEARCH, '0, '0);
    queue_request(ACT_REMOVE, '0, '0);
    queue_request(ACT_SEARCH, '0, '0);
    queue_request(ACT_REMOVE, MinValue, '0);
    queue_request(ACT_REMOVE, MaxValue, '0);
    queue_request(ACT_REMOVE, 12345, '0);
    queue_request(ACT_READ, '0, 4'd1);
    queue_random(RandomBeats);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() > 0 || beats_taken != beats_sent ||
           pending_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (!mismatch_seen && pending_outcomes.size() == 0) begin
      $display("sorted_value_list_core regression: pass");
    end else begin
      $display("sorted_value_list_core regression: fail");
    end
    $finish;
  end

endmodule
